/* rtl/bppf_pkg.sv */
package bppf_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd3;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_COMMAND = 3'd2;
  localparam logic [2:0] KIND_ADDRESS = 3'd3;
  localparam logic [2:0] KIND_DATA    = 3'd4;
  localparam logic [2:0] KIND_CRC     = 3'd5;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [15:0] PREAMBLE_LEN = 16'd5;

  // one classified data byte, with the framing fields of its chunk
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last_in_chunk;
    logic [7:0]  hdr;
    logic [7:0]  cmd;
    logic [31:0] addr;
    logic [15:0] plen;
  } entry_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* rtl/bppf_front.sv */
module bppf_front #(
  parameter int unsigned MAX_CHUNK = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [bppf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_take,
  input  logic [7:0]                      in_data_byte,
  output logic                            push,
  output bppf_pkg::entry_t                push_entry
);
  import bppf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNK + 1);
  localparam logic [15:0] MaxChunk16 = 16'(MAX_CHUNK);

  logic [7:0]    hdr_r, hdr_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [15:0]   total_r, total_nxt;
  logic [CW-1:0] chunk_r, chunk_nxt;

  logic          first;
  logic [15:0]   len16;
  logic [CW-1:0] chunk_cur;

  assign first     = (chunk_r == '0);
  assign len16     = (total_r < MaxChunk16) ? total_r : MaxChunk16;
  assign chunk_cur = first ? len16[CW-1:0] : chunk_r;
  assign push      = in_take && (total_r != 16'd0);

  always_comb begin
    push_entry.data          = in_data_byte;
    push_entry.first         = first;
    push_entry.last_in_chunk = (chunk_cur == CW'(1));
    push_entry.hdr           = hdr_r;
    push_entry.cmd           = cmd_r;
    push_entry.addr          = addr_r;
    push_entry.plen          = len16 + PREAMBLE_LEN;
  end

  always_comb begin
    hdr_nxt   = hdr_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    total_nxt = total_r;
    chunk_nxt = chunk_r;
    if (push) begin
      total_nxt = total_r - 16'd1;
      chunk_nxt = chunk_cur - CW'(1);
      if (first) begin
        addr_nxt = addr_r + {16'd0, len16};
      end
    end
    // the user keeps this written only while idle, so it never collides with a push; not enforced by the block
    if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER:  hdr_nxt = cfg_data[7:0];
        REG_COMMAND: cmd_nxt = cfg_data[7:0];
        REG_ADDRESS: addr_nxt = cfg_data;
        REG_LENGTH: begin
          total_nxt = cfg_data[15:0];
          chunk_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= 8'd128;
      cmd_r   <= 8'd32;
      addr_r  <= 32'd0;
      total_r <= 16'd0;
      chunk_r <= '0;
    end else begin
      hdr_r   <= hdr_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      total_r <= total_nxt;
      chunk_r <= chunk_nxt;
    end
  end

endmodule

/* rtl/bppf_queue.sv */
module bppf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bppf_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output bppf_pkg::entry_t head
);
  import bppf_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/bppf_back.sv */
module bppf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  bppf_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_byte_kind,
  output logic             out_frame_end,
  output logic             out_last
);
  import bppf_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PRE  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic [2:0]  kind_r;
  logic        end_r;
  logic        last_r;

  logic        out_ld;
  logic        prod;
  logic        crc_en;
  logic [7:0]  ob;
  logic [2:0]  ok;
  logic        oe;
  logic        ol;
  logic [31:0] crc_upd;
  logic [31:0] addr_sh;
  logic [31:0] crc_sh;

  assign out_ld  = !valid_r || !out_stall;
  assign crc_upd = crc_byte(crc_r, ob);
  assign addr_sh = head.addr >> {cnt_r[1:0], 3'b000};
  assign crc_sh  = crc_r >> {cnt_r[1:0], 3'b000};

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    pop     = 1'b0;
    prod    = 1'b0;
    crc_en  = 1'b0;
    ob      = head.data;
    ok      = KIND_DATA;
    oe      = 1'b0;
    ol      = 1'b0;
    case (ph_r)
      PH_IDLE, PH_BODY: begin
        if (out_ld && head_valid) begin
          prod = 1'b1;
          if (ph_r == PH_IDLE && head.first) begin
            ob      = head.hdr;
            ok      = KIND_HEADER;
            crc_nxt = CRC_INIT;
            cnt_nxt = 3'd1;
            ph_nxt  = PH_PRE;
          end else begin
            crc_en = 1'b1;
            pop    = 1'b1;
            if (head.last_in_chunk) begin
              cnt_nxt = 3'd0;
              ph_nxt  = PH_CRC;
            end else begin
              ol     = 1'b1;
              ph_nxt = PH_IDLE;
            end
          end
        end
      end
      PH_PRE: begin
        if (out_ld) begin
          prod    = 1'b1;
          cnt_nxt = cnt_r + 3'd1;
          case (cnt_r)
            3'd1: begin
              ob = head.plen[7:0];
              ok = KIND_LENGTH;
            end
            3'd2: begin
              ob = head.plen[15:8];
              ok = KIND_LENGTH;
            end
            3'd3: begin
              ob     = head.cmd;
              ok     = KIND_COMMAND;
              crc_en = 1'b1;
            end
            default: begin
              ob     = addr_sh[7:0];
              ok     = KIND_ADDRESS;
              crc_en = 1'b1;
            end
          endcase
          if (cnt_r == 3'd7) begin
            ph_nxt = PH_BODY;
          end
        end
      end
      PH_CRC: begin
        if (out_ld) begin
          prod    = 1'b1;
          ob      = crc_sh[7:0];
          ok      = KIND_CRC;
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            oe     = 1'b1;
            ol     = 1'b1;
            ph_nxt = PH_IDLE;
          end
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
    if (crc_en) begin
      crc_nxt = crc_upd;
    end
  end

  always_comb begin
    if (prod) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod) begin
      byte_r <= ob;
      kind_r <= ok;
      end_r  <= oe;
      last_r <= ol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IDLE;
      cnt_r   <= 3'd0;
      crc_r   <= CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_byte_kind = kind_r;
  assign out_frame_end = end_r;
  assign out_last      = last_r;

`ifndef SYNTHESIS
  // the chunk's entry stays at the queue head through its preamble
  a_pre_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_PRE || ph_r == PH_BODY) |-> head_valid)
    else $error("preamble running without a queued entry");

  a_end_is_last_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && end_r) |-> (last_r && kind_r == KIND_CRC))
    else $error("frame end not on the closing crc byte");

  // a stalled header keeps the first preamble step in place
  a_header_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_PRE && cnt_r == 3'd1) |->
      $past(ph_r == PH_IDLE || (ph_r == PH_PRE && cnt_r == 3'd1)))
    else $error("preamble entered other than from idle");
`endif

endmodule

/* rtl/bootloader_program_packet_framer_core.sv */
// Cuts image bytes into program-data packets of at most MAX_CHUNK data bytes:
// header, 16-bit length, command, 4-byte address, data, then a reflected CRC-32
// over command, address and data (start all ones, no final inversion), each
// multi-byte field low byte first. A front end classifies each accepted byte
// and a two-entry queue feeds the byte sequencer, which drives one output byte
// per cycle while out_stall is low and the queue is not empty, through a
// registered output stage. A chunk's first byte is preceded by eight preamble
// bytes and its last is followed by four CRC bytes, so n data bytes give n + 12
// output bytes. Bytes past total_length are accepted and dropped. The user must
// configure only while idle, which is not enforced; cfg_ready is always high.
module bootloader_program_packet_framer_core #(
  parameter int unsigned MAX_CHUNK = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bppf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic [2:0]                      out_byte_kind,
  output logic                            out_frame_end,
  output logic                            out_last
);
  import bppf_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   full;
  logic   head_valid;
  entry_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;

  bppf_front #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_take     (in_valid && !full),
    .in_data_byte(in_data_byte),
    .push        (push),
    .push_entry  (push_entry)
  );

  bppf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  bppf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_byte_kind(out_byte_kind),
    .out_frame_end(out_frame_end),
    .out_last     (out_last)
  );

endmodule
